### rtl/wwsl_pkg.sv
// ---------------------------------------------------------------------------
// wwsl_pkg: shared types and constants for the word wrap screen layout
// Word and result formats, grid geometry, controller states and the
// command and status groups between controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package wwsl_pkg;

  // Grid geometry
  localparam int ROW_CELLS = 60;
  localparam int GRID_ROWS = 19;

  localparam int COL_W  = 6;                    // holds 0..ROW_CELLS
  localparam int ROW_W  = 5;                    // holds 0..GRID_ROWS
  localparam int ADDR_W = $clog2(ROW_CELLS);    // word buffer address
  localparam int SUM_W  = COL_W + 1;            // column plus word length

  localparam logic [COL_W-1:0] COL_FULL = COL_W'(ROW_CELLS);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_ROWS - 1);
  localparam logic [SUM_W-1:0] SUM_LIM  = SUM_W'(ROW_CELLS);

  // Character codes
  localparam logic [7:0] CH_NL = 8'd10;
  localparam logic [7:0] CH_SP = 8'd32;

  // Input actions
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_CHAR  = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_CELL    = 2'd0;
  localparam logic [1:0] KIND_ROW_END = 2'd1;
  localparam logic [1:0] KIND_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] ch;
    logic       at_cursor;
    logic       starts_line;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [7:0]       glyph;
    logic             cursor_here;
    logic             editable;
    logic             last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_RESOLVE,
    S_FULL,
    S_TAIL,
    S_WRAP,
    S_FL_RD,
    S_FL_WR,
    S_FINISH
  } state_e;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_CELL_IN,
    EM_CELL_WORD,
    EM_ROW_END,
    EM_FULL
  } emit_e;

  // Controller to datapath
  typedef struct packed {
    logic  load_item;
    logic  frame_start;
    emit_e emit_sel;
    logic  re_item;      // row end carries the word's cursor and line_fresh
    logic  adv_row;
    logic  lf_set;
    logic  lf_clr;
    logic  close;
    logic  word_start;
    logic  word_append;
    logic  flush_init;
    logic  mem_rd;
    logic  flush_end;
    logic  finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] act;
    logic       is_nl;
    logic       is_sp;
    logic       closed;
    logic       holding;
    logic       col_full;
    logic       col_zero;
    logic       pws;
    logic       last_row;
    logic       wrap_need;
    logic       flush_last;
    logic       out_free;
    logic       hold_valid;
  } sts_t;

endpackage

`default_nettype wire

### rtl/wwsl_ctrl.sv
// ---------------------------------------------------------------------------
// wwsl_ctrl: layout sequencer
// Walks one input word through flush, full-row resolution, the action
// itself and the word-wrap check, issuing commands to the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

module wwsl_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wwsl_pkg::sts_t      sts_i,
  output wwsl_pkg::cmd_t      cmd_o
);

  wwsl_pkg::state_e state_q, state_d;
  logic is_word;
  logic is_sep;

  // Word character versus separator / end
  assign is_word = (sts_i.act == wwsl_pkg::ACT_CHAR) && !sts_i.is_nl && !sts_i.is_sp;
  assign is_sep  = (sts_i.act == wwsl_pkg::ACT_END) ||
                   ((sts_i.act == wwsl_pkg::ACT_CHAR) && (sts_i.is_nl || sts_i.is_sp));

  assign in_stall_o = (state_q != wwsl_pkg::S_IDLE);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wwsl_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.emit_sel = wwsl_pkg::EM_NONE;
    unique case (state_q)
      wwsl_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = wwsl_pkg::S_DISPATCH;
        end
      end
      wwsl_pkg::S_DISPATCH: begin
        if (sts_i.act == wwsl_pkg::ACT_START) begin
          cmd_o.frame_start = 1'b1;
          state_d = wwsl_pkg::S_IDLE;
        end else if (sts_i.closed || !(is_sep || is_word)) begin
          state_d = wwsl_pkg::S_IDLE;
        end else if (is_sep) begin
          if (sts_i.holding) begin
            cmd_o.flush_init = 1'b1;
            state_d = wwsl_pkg::S_FL_RD;
          end else begin
            state_d = wwsl_pkg::S_RESOLVE;
          end
        end else if (sts_i.holding) begin
          cmd_o.word_append = 1'b1;
          state_d = wwsl_pkg::S_WRAP;
        end else begin
          state_d = wwsl_pkg::S_RESOLVE;
        end
      end
      // A full row closes (wrapped) before anything else lands
      wwsl_pkg::S_RESOLVE: begin
        if (!sts_i.col_full) begin
          state_d = wwsl_pkg::S_TAIL;
        end else if (sts_i.out_free) begin
          cmd_o.emit_sel = wwsl_pkg::EM_ROW_END;
          cmd_o.adv_row  = 1'b1;
          cmd_o.lf_clr   = 1'b1;
          state_d = sts_i.last_row ? wwsl_pkg::S_FULL : wwsl_pkg::S_TAIL;
        end
      end
      wwsl_pkg::S_FULL: begin
        if (sts_i.out_free) begin
          cmd_o.emit_sel = wwsl_pkg::EM_FULL;
          state_d = wwsl_pkg::S_FINISH;
        end
      end
      wwsl_pkg::S_TAIL: begin
        if (sts_i.act == wwsl_pkg::ACT_END) begin
          if (sts_i.out_free) begin
            cmd_o.emit_sel = wwsl_pkg::EM_ROW_END;
            cmd_o.re_item  = 1'b1;
            cmd_o.close    = 1'b1;
            state_d = wwsl_pkg::S_FINISH;
          end
        end else if (sts_i.is_nl) begin
          if (sts_i.out_free) begin
            cmd_o.emit_sel = wwsl_pkg::EM_ROW_END;
            cmd_o.re_item  = 1'b1;
            cmd_o.adv_row  = 1'b1;
            cmd_o.lf_set   = 1'b1;
            state_d = sts_i.last_row ? wwsl_pkg::S_FULL : wwsl_pkg::S_FINISH;
          end
        end else if (is_word && !sts_i.col_zero && sts_i.pws) begin
          // Word after a space on a used row: hold it back
          cmd_o.word_start = 1'b1;
          state_d = wwsl_pkg::S_FINISH;
        end else if (sts_i.out_free) begin
          cmd_o.emit_sel = wwsl_pkg::EM_CELL_IN;
          state_d = wwsl_pkg::S_FINISH;
        end
      end
      // Held word no longer fits: end the row, carry the word down
      wwsl_pkg::S_WRAP: begin
        if (!sts_i.wrap_need) begin
          state_d = wwsl_pkg::S_FINISH;
        end else if (sts_i.out_free) begin
          cmd_o.emit_sel = wwsl_pkg::EM_ROW_END;
          cmd_o.adv_row  = 1'b1;
          cmd_o.lf_clr   = 1'b1;
          if (sts_i.last_row) begin
            state_d = wwsl_pkg::S_FULL;
          end else begin
            cmd_o.flush_init = 1'b1;
            state_d = wwsl_pkg::S_FL_RD;
          end
        end
      end
      wwsl_pkg::S_FL_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = wwsl_pkg::S_FL_WR;
      end
      wwsl_pkg::S_FL_WR: begin
        if (sts_i.out_free) begin
          cmd_o.emit_sel = wwsl_pkg::EM_CELL_WORD;
          if (sts_i.flush_last) begin
            cmd_o.flush_end = 1'b1;
            state_d = is_word ? wwsl_pkg::S_FINISH : wwsl_pkg::S_RESOLVE;
          end else begin
            state_d = wwsl_pkg::S_FL_RD;
          end
        end
      end
      wwsl_pkg::S_FINISH: begin
        if (sts_i.out_free || !sts_i.hold_valid) begin
          cmd_o.finish = 1'b1;
          state_d = wwsl_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = wwsl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/wwsl_dp.sv
// ---------------------------------------------------------------------------
// wwsl_dp: layout datapath
// Write position, line flags, held-word buffer, a one-result holding stage
// that lets the final result of a word be marked, and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module wwsl_dp (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wwsl_pkg::in_item_t   in_data_i,
  input  wwsl_pkg::cmd_t       cmd_i,
  output wwsl_pkg::sts_t       sts_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output wwsl_pkg::out_item_t  out_data_o
);

  wwsl_pkg::in_item_t  item_q;
  wwsl_pkg::out_item_t res_new;
  wwsl_pkg::out_item_t hold_q;
  wwsl_pkg::out_item_t out_q;
  wwsl_pkg::out_item_t push_item;
  logic                hold_vld_q;
  logic                out_vld_q;

  logic [wwsl_pkg::ROW_W-1:0]  row_q;
  logic [wwsl_pkg::COL_W-1:0]  col_q;
  logic [wwsl_pkg::COL_W-1:0]  wc_q;
  logic [wwsl_pkg::ADDR_W-1:0] idx_q;
  logic                        lf_q;
  logic                        pws_q;
  logic                        holding_q;
  logic                        closed_q;
  logic [8:0]                  rdata_q;
  logic [8:0]                  mem [wwsl_pkg::ROW_CELLS];

  logic out_free;
  logic push_mid;
  logic push_last;
  logic is_cell;

  assign out_free  = !out_vld_q || !out_stall_i;
  assign push_mid  = (cmd_i.emit_sel != wwsl_pkg::EM_NONE) && hold_vld_q;
  assign push_last = cmd_i.finish && hold_vld_q;
  assign is_cell   = (cmd_i.emit_sel == wwsl_pkg::EM_CELL_IN) ||
                     (cmd_i.emit_sel == wwsl_pkg::EM_CELL_WORD);

  // Status back to the sequencer
  always_comb begin
    sts_o.act        = item_q.action;
    sts_o.is_nl      = (item_q.ch == wwsl_pkg::CH_NL);
    sts_o.is_sp      = (item_q.ch == wwsl_pkg::CH_SP);
    sts_o.closed     = closed_q;
    sts_o.holding    = holding_q;
    sts_o.col_full   = (col_q == wwsl_pkg::COL_FULL);
    sts_o.col_zero   = (col_q == '0);
    sts_o.pws        = pws_q;
    sts_o.last_row   = (row_q == wwsl_pkg::ROW_LAST);
    sts_o.wrap_need  = (wwsl_pkg::SUM_W'(col_q) + wwsl_pkg::SUM_W'(wc_q)) > wwsl_pkg::SUM_LIM;
    sts_o.flush_last = (wwsl_pkg::SUM_W'(idx_q) + wwsl_pkg::SUM_W'(1)) ==
                       wwsl_pkg::SUM_W'(wc_q);
    sts_o.out_free   = out_free;
    sts_o.hold_valid = hold_vld_q;
  end

  // Result formatting
  always_comb begin
    res_new = '0;
    unique case (cmd_i.emit_sel)
      wwsl_pkg::EM_CELL_IN: begin
        res_new.kind        = wwsl_pkg::KIND_CELL;
        res_new.row         = row_q;
        res_new.col         = col_q;
        res_new.glyph       = item_q.ch;
        res_new.cursor_here = item_q.at_cursor;
      end
      wwsl_pkg::EM_CELL_WORD: begin
        res_new.kind        = wwsl_pkg::KIND_CELL;
        res_new.row         = row_q;
        res_new.col         = col_q;
        res_new.glyph       = rdata_q[7:0];
        res_new.cursor_here = rdata_q[8];
      end
      wwsl_pkg::EM_ROW_END: begin
        res_new.kind        = wwsl_pkg::KIND_ROW_END;
        res_new.row         = row_q;
        res_new.col         = col_q;
        res_new.cursor_here = cmd_i.re_item && item_q.at_cursor;
        res_new.editable    = cmd_i.re_item && lf_q;
      end
      wwsl_pkg::EM_FULL: begin
        res_new.kind = wwsl_pkg::KIND_FULL;
      end
      default: begin
        res_new = '0;
      end
    endcase
  end

  // Result leaving the holding stage, with its final-result mark
  always_comb begin
    push_item      = hold_q;
    push_item.last = push_last;
  end

  // Layout state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      lf_q      <= 1'b1;
      pws_q     <= 1'b0;
      wc_q      <= '0;
      holding_q <= 1'b0;
      closed_q  <= 1'b0;
      idx_q     <= '0;
    end else if (cmd_i.frame_start) begin
      row_q     <= '0;
      col_q     <= '0;
      lf_q      <= item_q.starts_line;
      pws_q     <= 1'b0;
      wc_q      <= '0;
      holding_q <= 1'b0;
      closed_q  <= 1'b0;
    end else begin
      if (is_cell) begin
        col_q <= col_q + wwsl_pkg::COL_W'(1);
      end
      if (cmd_i.emit_sel == wwsl_pkg::EM_CELL_WORD) begin
        idx_q <= idx_q + wwsl_pkg::ADDR_W'(1);
      end
      if (cmd_i.adv_row) begin
        row_q <= row_q + wwsl_pkg::ROW_W'(1);
        col_q <= '0;
      end
      if (cmd_i.lf_set) begin
        lf_q <= 1'b1;
      end else if (cmd_i.lf_clr) begin
        lf_q <= 1'b0;
      end
      if (cmd_i.close || (cmd_i.emit_sel == wwsl_pkg::EM_FULL)) begin
        closed_q <= 1'b1;
      end
      if (cmd_i.word_start) begin
        wc_q      <= wwsl_pkg::COL_W'(1);
        holding_q <= 1'b1;
      end else if (cmd_i.word_append && (wc_q != wwsl_pkg::COL_FULL)) begin
        wc_q <= wc_q + wwsl_pkg::COL_W'(1);
      end
      if (cmd_i.flush_end || (cmd_i.emit_sel == wwsl_pkg::EM_FULL)) begin
        wc_q      <= '0;
        holding_q <= 1'b0;
      end
      if (cmd_i.flush_init) begin
        idx_q <= '0;
      end
      if (cmd_i.finish && (item_q.action == wwsl_pkg::ACT_CHAR)) begin
        pws_q <= sts_o.is_nl || sts_o.is_sp;
      end
    end
  end

  // Holding stage and output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.emit_sel != wwsl_pkg::EM_NONE) begin
        hold_vld_q <= 1'b1;
      end else if (cmd_i.finish) begin
        hold_vld_q <= 1'b0;
      end
      if (push_mid || push_last) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    if (cmd_i.emit_sel != wwsl_pkg::EM_NONE) begin
      hold_q <= res_new;
    end
    if (push_mid || push_last) begin
      out_q <= push_item;
    end
  end

  // Held-word buffer: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.word_start) begin
      mem[0] <= {item_q.at_cursor, item_q.ch};
    end else if (cmd_i.word_append && (wc_q != wwsl_pkg::COL_FULL)) begin
      mem[wc_q[wwsl_pkg::ADDR_W-1:0]] <= {item_q.at_cursor, item_q.ch};
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[idx_q];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Checks
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_sel != wwsl_pkg::EM_NONE) |-> out_free)
    else $error("result emitted while output stage is blocked");

  a_hold_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    holding_q == (wc_q != '0))
    else $error("held-word flag disagrees with word length");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= wwsl_pkg::COL_FULL)
    else $error("column beyond row width");

  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && hold_vld_q) |=> (out_vld_q && out_q.last))
    else $error("final result of a word not marked last");

endmodule

`default_nettype wire

### rtl/word_wrap_screen_layout.sv
// A word is taken only while the sequencer is idle; the input stalls until it
// has finished the word, so a new word waits for the last one to be done.
// Results pass through a holding stage before the output register; each
// character of a held word written out takes a buffer read, then a cell write.
// A stalled output register holds the sequencer until the result is taken.
// Reset: position, flags and word length clear, line_fresh sets; buffer uncleared.
// ---------------------------------------------------------------------------
// word_wrap_screen_layout: greedy word-wrap layout into a character grid
// Sequencer plus datapath; emits cell writes, row-end records and a
// frame-full record for a stream of document characters.
// ---------------------------------------------------------------------------
`default_nettype none

module word_wrap_screen_layout (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wwsl_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output wwsl_pkg::out_item_t  out_data_o
);

  wwsl_pkg::cmd_t cmd;
  wwsl_pkg::sts_t sts;

  // Sequencer
  wwsl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath
  wwsl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### sim/word_wrap_screen_layout_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_wrap_screen_layout_test: self-checking bench for the word wrap layout
// Sends directed and random documents to the layout block in bursty input
// words, with the result side stalling on its own pattern. A behavioural
// layout model predicts every cell write, row record and frame-full record,
// and each result is checked in order against it.
// ----------------------------------------------------------------------------
module word_wrap_screen_layout_test;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 12;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_WORDS  = 40;
  localparam int MAX_REPORTS   = 10;

  // Action code that the block ignores
  localparam logic [1:0] ACT_NONE = 2'd3;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  typedef enum int {
    DOC_SHORT_LINES,
    DOC_PARAGRAPH,
    DOC_LONG_WORDS,
    DOC_BLANK_LINES
  } doc_style_e;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  wwsl_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  wwsl_pkg::out_item_t out_data;

  word_wrap_screen_layout dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Layout model state
  // --------------------------------------------------------------------------
  logic [wwsl_pkg::ROW_W-1:0] at_row;
  logic [wwsl_pkg::COL_W-1:0] at_col;
  logic                       fresh_line;     // row not entered by a wrap
  logic                       after_space;
  logic                       word_open;      // a text word is being held back
  logic                       layout_closed;
  logic [8:0]                 word_buf [wwsl_pkg::ROW_CELLS];
  int                         word_len;

  wwsl_pkg::out_item_t pending_layout[$];
  int                  live_words = 0;        // words that the block acts on
  int                  mismatches = 0;
  int                  burst_left = 0;
  bit                  no_gaps    = 1'b0;

  function automatic void clear_layout();
    at_row        = '0;
    at_col        = '0;
    fresh_line    = 1'b1;
    after_space   = 1'b0;
    word_open     = 1'b0;
    layout_closed = 1'b0;
    word_len      = 0;
  endfunction

  function automatic void emit_result(logic [1:0] k, logic [wwsl_pkg::ROW_W-1:0] r,
                                      logic [wwsl_pkg::COL_W-1:0] c, logic [7:0] g,
                                      logic cur, logic ed);
    wwsl_pkg::out_item_t o;
    o.kind        = k;
    o.row         = r;
    o.col         = c;
    o.glyph       = g;
    o.cursor_here = cur;
    o.editable    = ed;
    o.last        = 1'b0;
    pending_layout.push_back(o);
  endfunction

  // Row end and advance; 0 once the grid has run out of rows
  function automatic bit close_row(logic [wwsl_pkg::COL_W-1:0] len, logic cur, logic ed);
    emit_result(wwsl_pkg::KIND_ROW_END, at_row, len, 8'h00, cur, ed);
    at_row = at_row + 1'b1;
    at_col = '0;
    if (at_row >= wwsl_pkg::GRID_ROWS) begin
      emit_result(wwsl_pkg::KIND_FULL, '0, '0, 8'h00, 1'b0, 1'b0);
      layout_closed = 1'b1;
      word_open     = 1'b0;
      word_len      = 0;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void put_glyph(logic [7:0] g, logic cur);
    emit_result(wwsl_pkg::KIND_CELL, at_row, at_col, g, cur, 1'b0);
    at_col = at_col + 1'b1;
  endfunction

  // A full row ends (wrapped) only when something further arrives
  function automatic bit settle_full_row();
    if (at_col >= wwsl_pkg::COL_FULL) begin
      fresh_line = 1'b0;
      return close_row(at_col, 1'b0, 1'b0);
    end
    return 1'b1;
  endfunction

  function automatic void flush_held();
    for (int i = 0; i < word_len; i++)
      put_glyph(word_buf[i][7:0], word_buf[i][8]);
    word_len  = 0;
    word_open = 1'b0;
  endfunction

  // Predict the results of one accepted word
  function automatic void lay_out_word(wwsl_pkg::in_item_t w);
    int                  first;
    logic                ed;
    wwsl_pkg::out_item_t tail;
    first = pending_layout.size();
    if (w.action == wwsl_pkg::ACT_START) begin
      clear_layout();
      fresh_line = w.starts_line;
      live_words++;
      return;
    end
    if (layout_closed || w.action == ACT_NONE) return;
    live_words++;

    if (w.action == wwsl_pkg::ACT_END) begin
      if (word_open) flush_held();
      if (settle_full_row()) begin
        emit_result(wwsl_pkg::KIND_ROW_END, at_row, at_col, 8'h00, w.at_cursor,
                    fresh_line);
        layout_closed = 1'b1;
      end
    end else if (w.ch == wwsl_pkg::CH_NL) begin
      if (word_open) flush_held();
      if (settle_full_row()) begin
        ed         = fresh_line;
        fresh_line = 1'b1;
        void'(close_row(at_col, w.at_cursor, ed));
      end
      after_space = 1'b1;
    end else if (w.ch == wwsl_pkg::CH_SP) begin
      if (word_open) flush_held();
      if (settle_full_row()) put_glyph(w.ch, w.at_cursor);
      after_space = 1'b1;
    end else if (word_open) begin
      if (word_len < wwsl_pkg::ROW_CELLS) begin
        word_buf[word_len] = {w.at_cursor, w.ch};
        word_len++;
      end
      // held word no longer fits: wrap it onto the next row
      if (int'(at_col) + word_len > wwsl_pkg::ROW_CELLS) begin
        fresh_line = 1'b0;
        if (close_row(at_col, 1'b0, 1'b0)) flush_held();
      end
      after_space = 1'b0;
    end else begin
      if (settle_full_row()) begin
        if (at_col != '0 && after_space) begin
          word_open   = 1'b1;
          word_buf[0] = {w.at_cursor, w.ch};
          word_len    = 1;
        end else begin
          put_glyph(w.ch, w.at_cursor);
        end
      end
      after_space = 1'b0;
    end

    if (pending_layout.size() > first) begin
      tail      = pending_layout[pending_layout.size() - 1];
      tail.last = 1'b1;
      pending_layout[pending_layout.size() - 1] = tail;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  function automatic void report_mismatch(string what, wwsl_pkg::out_item_t want,
                                          wwsl_pkg::out_item_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t %s: expected kind %0d row %0d col %0d glyph %02h cur %0b ed %0b last %0b",
               $realtime, what, want.kind, want.row, want.col, want.glyph,
               want.cursor_here, want.editable, want.last);
      $display("    got kind %0d row %0d col %0d glyph %02h cur %0b ed %0b last %0b",
               got.kind, got.row, got.col, got.glyph, got.cursor_here,
               got.editable, got.last);
    end
  endfunction

  function automatic void check_layout(wwsl_pkg::out_item_t got);
    wwsl_pkg::out_item_t want;
    if (pending_layout.size() == 0) begin
      report_mismatch("unexpected result", '0, got);
      return;
    end
    want = pending_layout.pop_front();
    if (got.kind !== want.kind || got.row !== want.row || got.col !== want.col ||
        got.glyph !== want.glyph || got.cursor_here !== want.cursor_here ||
        got.editable !== want.editable || got.last !== want.last)
      report_mismatch("result mismatch", want, got);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) check_layout(out_data);
  end

  // Result side stalls in spans of differing character
  initial begin : result_stall
    stall_mode_e mode;
    int          span;
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      for (int phase = 0; phase < span; phase++) begin
        @(negedge clk_i);
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
          default:     out_stall <= ((phase % 7) < 3);
        endcase
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // One word on the input channel, in bursts with random gaps between them
  task automatic send_word(input wwsl_pkg::in_item_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = no_gaps ? 0 : $urandom_range(0, 6);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk_i); while (in_stall);
    lay_out_word(w);
  endtask

  task automatic send_fields(input logic [1:0] act, input logic [7:0] c,
                             input logic cur, input logic sl);
    wwsl_pkg::in_item_t w;
    w.action      = act;
    w.ch          = c;
    w.at_cursor   = cur;
    w.starts_line = sl;
    send_word(w);
  endtask

  // Hold the input off until every expected result has come out
  task automatic drain_layout();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_layout.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] word_glyph();
    logic [7:0] g;
    do g = 8'($urandom_range(0, 255)); while (g == wwsl_pkg::CH_NL || g == wwsl_pkg::CH_SP);
    return g;
  endfunction

  function automatic logic rand_cursor();
    return ($urandom_range(0, 7) == 0);
  endfunction

  task automatic send_text(input int len);
    repeat (len)
      send_fields(wwsl_pkg::ACT_CHAR, word_glyph(), rand_cursor(), 1'($urandom_range(0, 1)));
  endtask

  // Short document: glyph extremes, held words, cursor, closed frame
  task automatic test_basics();
    send_fields(wwsl_pkg::ACT_START, 8'h00, 1'b0, 1'b1);
    send_fields(wwsl_pkg::ACT_CHAR, 8'h41, 1'b1, 1'b0);
    send_fields(wwsl_pkg::ACT_CHAR, 8'hFF, 1'b0, 1'b1);
    send_fields(wwsl_pkg::ACT_CHAR, wwsl_pkg::CH_SP, 1'b1, 1'b0);
    send_fields(wwsl_pkg::ACT_CHAR, 8'h00, 1'b1, 1'b0);   // held, cursor inside
    send_fields(wwsl_pkg::ACT_CHAR, 8'h7E, 1'b0, 1'b0);
    send_fields(wwsl_pkg::ACT_CHAR, wwsl_pkg::CH_NL, 1'b1, 1'b0);   // flush, editable end
    send_fields(ACT_NONE, 8'hFF, 1'b1, 1'b1);
    send_fields(wwsl_pkg::ACT_CHAR, wwsl_pkg::CH_SP, 1'b0, 1'b0);   // space at row start
    send_fields(wwsl_pkg::ACT_CHAR, 8'h80, 1'b0, 1'b0);
    send_fields(wwsl_pkg::ACT_END, 8'h00, 1'b1, 1'b0);    // flush, row end, close
    send_fields(wwsl_pkg::ACT_CHAR, 8'h41, 1'b1, 1'b1);   // frame closed
    send_fields(wwsl_pkg::ACT_END, 8'hFF, 1'b1, 1'b1);
    send_fields(wwsl_pkg::ACT_START, 8'hFF, 1'b1, 1'b0);  // view mid-line
    send_fields(wwsl_pkg::ACT_CHAR, 8'h01, 1'b0, 1'b0);
    send_fields(wwsl_pkg::ACT_CHAR, wwsl_pkg::CH_NL, 1'b0, 1'b1);   // not editable
    send_fields(wwsl_pkg::ACT_CHAR, wwsl_pkg::CH_NL, 1'b1, 1'b0);   // empty editable row
    send_fields(wwsl_pkg::ACT_CHAR, 8'h55, 1'b0, 1'b0);
    send_fields(wwsl_pkg::ACT_CHAR, wwsl_pkg::CH_SP, 1'b0, 1'b0);
    send_fields(wwsl_pkg::ACT_CHAR, wwsl_pkg::CH_SP, 1'b0, 1'b0);
    send_fields(wwsl_pkg::ACT_END, 8'h00, 1'b0, 1'b0);
  endtask

  // A row filled exactly, then a word longer than a row split at the end
  task automatic test_full_rows();
    no_gaps = 1'b1;
    send_fields(wwsl_pkg::ACT_START, 8'h00, 1'b0, 1'b1);
    send_text(wwsl_pkg::ROW_CELLS);
    send_fields(wwsl_pkg::ACT_CHAR, wwsl_pkg::CH_SP, 1'b0, 1'b0);
    send_text(wwsl_pkg::ROW_CELLS + 15);
    send_fields(wwsl_pkg::ACT_END, 8'h00, 1'b1, 1'b0);
    no_gaps = 1'b0;
  endtask

  // Held words that overrun the row move to the next one
  task automatic test_word_wrap();
    send_fields(wwsl_pkg::ACT_START, 8'h00, 1'b0, 1'b0);
    send_text(wwsl_pkg::ROW_CELLS - 5);
    send_fields(wwsl_pkg::ACT_CHAR, wwsl_pkg::CH_SP, 1'b0, 1'b0);
    send_text(10);
    send_fields(wwsl_pkg::ACT_CHAR, wwsl_pkg::CH_SP, 1'b0, 1'b0);
    send_text(3);
    send_fields(wwsl_pkg::ACT_CHAR, wwsl_pkg::CH_NL, 1'b0, 1'b0);
    send_fields(wwsl_pkg::ACT_END, 8'h00, 1'b1, 1'b0);
  endtask

  // Grid runs out during a wrap and during a newline
  task automatic test_grid_exhaust();
    send_fields(wwsl_pkg::ACT_START, 8'h00, 1'b0, 1'b1);
    repeat (wwsl_pkg::GRID_ROWS - 1)
      send_fields(wwsl_pkg::ACT_CHAR, wwsl_pkg::CH_NL, rand_cursor(), 1'b0);
    send_text(50);
    send_fields(wwsl_pkg::ACT_CHAR, wwsl_pkg::CH_SP, 1'b0, 1'b0);
    send_text(20);                              // held word dropped
    send_text(2);
    send_fields(wwsl_pkg::ACT_END, 8'h00, 1'b1, 1'b0);
    drain_layout();
    send_fields(wwsl_pkg::ACT_START, 8'h00, 1'b0, 1'b1);
    repeat (wwsl_pkg::GRID_ROWS)
      send_fields(wwsl_pkg::ACT_CHAR, wwsl_pkg::CH_NL, rand_cursor(), 1'b0);
    send_fields(wwsl_pkg::ACT_END, 8'h00, 1'b0, 1'b0);
  endtask

  // Random documents of several styles with a little noise mixed in
  task automatic test_random_docs();
    int         goal;
    int         tokens;
    int         wlen;
    int         nl_odds;
    int         sep;
    doc_style_e style;
    goal = live_words + RANDOM_WORDS;
    while (live_words < goal) begin
      style   = doc_style_e'($urandom_range(0, 3));
      no_gaps = ($urandom_range(0, 3) == 0);
      send_fields(wwsl_pkg::ACT_START, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      tokens = $urandom_range(4, 40);
      for (int t = 0; t < tokens && live_words < goal; t++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_fields(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          case (style)
            DOC_SHORT_LINES: begin
              wlen    = $urandom_range(1, 8);
              nl_odds = 25;
            end
            DOC_PARAGRAPH: begin
              wlen    = $urandom_range(1, 14);
              nl_odds = 5;
            end
            DOC_LONG_WORDS: begin
              wlen    = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 75)
                                                     : $urandom_range(1, 10);
              nl_odds = 12;
            end
            default: begin
              wlen    = $urandom_range(0, 3);
              nl_odds = 60;
            end
          endcase
          send_text(wlen);
          sep = $urandom_range(0, 99);
          if (sep < nl_odds) begin
            send_fields(wwsl_pkg::ACT_CHAR, wwsl_pkg::CH_NL, rand_cursor(),
                        1'($urandom_range(0, 1)));
          end else begin
            send_fields(wwsl_pkg::ACT_CHAR, wwsl_pkg::CH_SP, rand_cursor(),
                        1'($urandom_range(0, 1)));
            if (sep >= 92)
              send_fields(wwsl_pkg::ACT_CHAR,
                          (sep[0] ? wwsl_pkg::CH_SP : wwsl_pkg::CH_NL),
                          rand_cursor(), 1'b0);
          end
        end
      end
      if ($urandom_range(0, 4) != 0)
        send_fields(wwsl_pkg::ACT_END, 8'($urandom_range(0, 255)), rand_cursor(),
                    1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    clear_layout();
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basics();
    test_full_rows();
    test_word_wrap();
    test_grid_exhaust();
    test_random_docs();

    drain_layout();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_layout.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### word_wrap_screen_layout.f
rtl/wwsl_pkg.sv
rtl/wwsl_ctrl.sv
rtl/wwsl_dp.sv
rtl/word_wrap_screen_layout.sv
sim/word_wrap_screen_layout_test.sv
